// ===== hdl/pmq_pkg.sv =====
// ----------------------------------------------------------------------------
// pmq_pkg
// Shared types and constants for the partitioned multi-queue block.
// ----------------------------------------------------------------------------
package pmq_pkg;

    localparam int TOTAL_SLOTS_DEF = 32;
    localparam int MAX_QUEUES_DEF  = 8;

    localparam int DATA_W     = 32;
    localparam int QCNT_W     = 4;
    localparam int QNUM_W     = 3;
    localparam int STATUS_W   = 2;
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    localparam logic [APB_ADDR_W-1:0] ADDR_QUEUE_COUNT = 3'd0;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2,
        ST_RANGE = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_LOAD
    } ctrl_state_t;

    typedef struct packed {
        logic capture;
        logic exec;
        logic load;
    } dp_cmd_t;

    typedef struct packed {
        logic out_free;
    } dp_stat_t;

    typedef struct packed {
        logic              we;
        logic [QCNT_W-1:0] value;
    } cfg_wr_t;

endpackage

// ===== hdl/pmq_ram.sv =====
// ----------------------------------------------------------------------------
// pmq_ram
// Generic single-port RAM with registered read data.
// ----------------------------------------------------------------------------
module pmq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== hdl/pmq_ctrl.sv =====
// ----------------------------------------------------------------------------
// pmq_ctrl
// Request sequencer: accept, execute against the pointers, load result.
// ----------------------------------------------------------------------------
module pmq_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  pmq_pkg::dp_stat_t stat,
    output pmq_pkg::dp_cmd_t  cmd
);

    import pmq_pkg::*;

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                state_next = S_LOAD;
            end
            S_LOAD:
            begin
                if (stat.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready    = 1'b0;
        cmd.capture = 1'b0;
        cmd.exec    = 1'b0;
        cmd.load    = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.capture = in_valid;
            end
            S_EXEC:
            begin
                cmd.exec = 1'b1;
            end
            S_LOAD:
            begin
                cmd.load = stat.out_free;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

endmodule

// ===== hdl/pmq_datapath.sv =====
// ----------------------------------------------------------------------------
// pmq_datapath
// Queue pointers, partition setup, slot store and result register.
// ----------------------------------------------------------------------------
module pmq_datapath #(
    parameter int TOTAL_SLOTS = pmq_pkg::TOTAL_SLOTS_DEF,
    parameter int MAX_QUEUES  = pmq_pkg::MAX_QUEUES_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  pmq_pkg::dp_cmd_t              cmd,
    output pmq_pkg::dp_stat_t             stat,
    input  pmq_pkg::cfg_wr_t              cfg,
    output logic [pmq_pkg::QCNT_W-1:0]    queue_count,
    input  logic                          in_mode,
    input  logic [pmq_pkg::QNUM_W-1:0]    in_queue,
    input  logic [pmq_pkg::DATA_W-1:0]    in_value,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [pmq_pkg::DATA_W-1:0]    out_value,
    output logic [pmq_pkg::STATUS_W-1:0]  out_status
);

    import pmq_pkg::*;

    localparam int IW = $clog2(TOTAL_SLOTS + 1);
    localparam int AW = $clog2(TOTAL_SLOTS);
    localparam int QW = (MAX_QUEUES > 1) ? $clog2(MAX_QUEUES) : 1;
    localparam int NW = $clog2(MAX_QUEUES + 1);
    localparam int EW = IW + QNUM_W;

    // partition size per effective queue count, index is count - 1
    logic [IW-1:0] ps_tab [MAX_QUEUES];
    for (genvar g = 0; g < MAX_QUEUES; g++)
    begin : g_ps
        localparam int PS = TOTAL_SLOTS / (g + 1);
        assign ps_tab[g] = IW'(PS);
    end

    logic [QCNT_W-1:0] qcount_reg, qcount_next;
    logic [NW-1:0]     active_reg, active_next;
    logic [IW-1:0]     psize_reg, psize_next;
    logic [IW-1:0]     head_reg [MAX_QUEUES];
    logic [IW-1:0]     head_next [MAX_QUEUES];
    logic [IW-1:0]     tail_reg [MAX_QUEUES];
    logic [IW-1:0]     tail_next [MAX_QUEUES];
    logic [MAX_QUEUES-1:0] nonempty_reg, nonempty_next;

    logic              req_mode_reg, req_mode_next;
    logic [QNUM_W-1:0] req_queue_reg, req_queue_next;
    logic [DATA_W-1:0] req_value_reg, req_value_next;
    status_t           status_reg, status_next;
    logic              take_data_reg, take_data_next;

    logic              out_valid_reg, out_valid_next;
    logic [DATA_W-1:0] out_value_reg, out_value_next;
    status_t           out_status_reg, out_status_next;

    logic [NW-1:0]     new_active;
    logic [IW-1:0]     new_ps;
    logic              in_range;
    logic [QW-1:0]     qidx;
    logic [EW-1:0]     start_w;
    logic [EW-1:0]     end_w;
    logic [IW-1:0]     cur_head;
    logic [IW-1:0]     cur_tail;
    logic [IW-1:0]     head_inc;
    logic              tail_full;
    logic              remove_ok;
    logic              ram_we;
    logic              ram_re;
    logic [AW-1:0]     ram_addr;
    logic [DATA_W-1:0] ram_rdata;

    always_comb
    begin
        if (cfg.value == '0)
        begin
            new_active = NW'(1);
        end
        else if (int'(cfg.value) > MAX_QUEUES)
        begin
            new_active = NW'(MAX_QUEUES);
        end
        else
        begin
            new_active = NW'(cfg.value);
        end
    end

    assign new_ps = ps_tab[QW'(new_active - NW'(1))];

    assign in_range  = int'(req_queue_reg) < int'(active_reg);
    assign qidx      = QW'(req_queue_reg);
    assign start_w   = EW'(req_queue_reg) * EW'(psize_reg);
    assign end_w     = start_w + EW'(psize_reg);
    assign cur_head  = head_reg[qidx];
    assign cur_tail  = tail_reg[qidx];
    assign head_inc  = cur_head + IW'(1);
    assign tail_full = (EW'(cur_tail) >= end_w) || (cur_tail >= IW'(TOTAL_SLOTS));
    assign remove_ok = nonempty_reg[qidx] && (cur_head < IW'(TOTAL_SLOTS));

    assign ram_we   = cmd.exec && in_range && !req_mode_reg && !tail_full;
    assign ram_re   = cmd.exec && in_range && req_mode_reg && remove_ok;
    assign ram_addr = req_mode_reg ? cur_head[AW-1:0] : cur_tail[AW-1:0];

    always_comb
    begin
        qcount_next    = qcount_reg;
        active_next    = active_reg;
        psize_next     = psize_reg;
        head_next      = head_reg;
        tail_next      = tail_reg;
        nonempty_next  = nonempty_reg;
        status_next    = status_reg;
        take_data_next = take_data_reg;

        if (cfg.we)
        begin
            qcount_next   = cfg.value;
            active_next   = new_active;
            psize_next    = new_ps;
            nonempty_next = '0;
            for (int i = 0; i < MAX_QUEUES; i++)
            begin
                head_next[i] = IW'(i * int'(new_ps));
                tail_next[i] = IW'(i * int'(new_ps));
            end
        end
        else if (cmd.exec)
        begin
            take_data_next = 1'b0;
            if (!in_range)
            begin
                status_next = ST_RANGE;
            end
            else if (!req_mode_reg)
            begin
                if (tail_full)
                begin
                    status_next = ST_FULL;
                end
                else
                begin
                    tail_next[qidx]     = cur_tail + IW'(1);
                    nonempty_next[qidx] = 1'b1;
                    status_next         = ST_DONE;
                end
            end
            else
            begin
                if (!remove_ok)
                begin
                    status_next = ST_EMPTY;
                end
                else
                begin
                    take_data_next = 1'b1;
                    status_next    = ST_DONE;
                    if (head_inc >= cur_tail)
                    begin
                        head_next[qidx]     = start_w[IW-1:0];
                        tail_next[qidx]     = start_w[IW-1:0];
                        nonempty_next[qidx] = 1'b0;
                    end
                    else
                    begin
                        head_next[qidx] = head_inc;
                    end
                end
            end
        end
    end

    always_comb
    begin
        req_mode_next  = req_mode_reg;
        req_queue_next = req_queue_reg;
        req_value_next = req_value_reg;
        if (cmd.capture)
        begin
            req_mode_next  = in_mode;
            req_queue_next = in_queue;
            req_value_next = in_value;
        end
    end

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_value_next  = out_value_reg;
        out_status_next = out_status_reg;
        if (cmd.load)
        begin
            out_valid_next  = 1'b1;
            out_value_next  = take_data_reg ? ram_rdata : '0;
            out_status_next = status_reg;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            qcount_reg    <= QCNT_W'(1);
            active_reg    <= NW'(1);
            psize_reg     <= IW'(TOTAL_SLOTS);
            nonempty_reg  <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < MAX_QUEUES; i++)
            begin
                head_reg[i] <= IW'(i * TOTAL_SLOTS);
                tail_reg[i] <= IW'(i * TOTAL_SLOTS);
            end
        end
        else
        begin
            qcount_reg    <= qcount_next;
            active_reg    <= active_next;
            psize_reg     <= psize_next;
            nonempty_reg  <= nonempty_next;
            out_valid_reg <= out_valid_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_mode_reg   <= req_mode_next;
        req_queue_reg  <= req_queue_next;
        req_value_reg  <= req_value_next;
        status_reg     <= status_next;
        take_data_reg  <= take_data_next;
        out_value_reg  <= out_value_next;
        out_status_reg <= out_status_next;
    end

    pmq_ram #(
        .WIDTH (DATA_W),
        .DEPTH (TOTAL_SLOTS)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .re    (ram_re),
        .addr  (ram_addr),
        .wdata (req_value_reg),
        .rdata (ram_rdata)
    );

    assign stat.out_free = !out_valid_reg || out_ready;
    assign queue_count   = qcount_reg;
    assign out_valid     = out_valid_reg;
    assign out_value     = out_value_reg;
    assign out_status    = out_status_reg;

`ifndef NO_ASSERTIONS
    a_head_le_tail: assert property (@(posedge clk) disable iff (!rst_n)
        head_reg[0] <= tail_reg[0])
        else $error("queue 0 head passed its tail");

    a_empty_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
        !nonempty_reg[0] |-> head_reg[0] == tail_reg[0])
        else $error("empty queue 0 with head and tail apart");

    a_psize_bound: assert property (@(posedge clk) disable iff (!rst_n)
        psize_reg <= IW'(TOTAL_SLOTS))
        else $error("partition size exceeds store");

    a_load_after_read: assert property (@(posedge clk) disable iff (!rst_n)
        ram_re |=> !cmd.capture && take_data_reg)
        else $error("store read not followed by result load");
`endif

endmodule

// ===== hdl/partitioned_multi_queue.sv =====
// ----------------------------------------------------------------------------
// partitioned_multi_queue
// Several linear queues sharing one word store in equal partitions.
// ----------------------------------------------------------------------------
// One request at a time: a request accepted on s_axis passes through capture,
// pointer update with store access and result load before its result sits in
// the output register, and the next request is accepted only after the result
// load. The single-port slot store is read in the pointer update step, and its
// registered read data is taken into the output register in the load step. A
// pending result waiting on m_axis does not stop the next request from being
// captured and executed, but its result load waits until the output register
// is free. Writing queue_count empties all queues in a single register update;
// there is no clearing pass. Store entries are not initialized.
module partitioned_multi_queue #(
    parameter int TOTAL_SLOTS = pmq_pkg::TOTAL_SLOTS_DEF,
    parameter int MAX_QUEUES  = pmq_pkg::MAX_QUEUES_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    // APB configuration
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [pmq_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [pmq_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [pmq_pkg::APB_DATA_W-1:0]   prdata,
    output logic                             pready,
    // request stream
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [31:0]                      s_axis_tdata,  // [31:0] value_in
    input  logic [3:0]                       s_axis_tuser,  // [0] mode, [3:1] queue_number
    // result stream
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [31:0]                      m_axis_tdata,  // [31:0] value_out
    output logic [1:0]                       m_axis_tuser   // [1:0] status
);

    import pmq_pkg::*;

    dp_cmd_t           cmd;
    dp_stat_t          stat;
    cfg_wr_t           cfg;
    logic [QCNT_W-1:0] queue_count;

    assign pready    = 1'b1;
    assign cfg.we    = psel && penable && pwrite && pready && (paddr == ADDR_QUEUE_COUNT);
    assign cfg.value = pwdata[QCNT_W-1:0];
    assign prdata    = (paddr == ADDR_QUEUE_COUNT) ? APB_DATA_W'(queue_count) : '0;

    pmq_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    pmq_datapath #(
        .TOTAL_SLOTS (TOTAL_SLOTS),
        .MAX_QUEUES  (MAX_QUEUES)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .stat        (stat),
        .cfg         (cfg),
        .queue_count (queue_count),
        .in_mode     (s_axis_tuser[0]),
        .in_queue    (s_axis_tuser[3:1]),
        .in_value    (s_axis_tdata),
        .out_valid   (m_axis_tvalid),
        .out_ready   (m_axis_tready),
        .out_value   (m_axis_tdata),
        .out_status  (m_axis_tuser)
    );

endmodule
